// ----- sv/pn_pkg.sv -----
`timescale 1ns / 1ps
package pn_pkg;

	// table and fixed-point sizes
	localparam int TBL_BITS   = 8;
	localparam int TBL_SIZE   = 1 << TBL_BITS;
	localparam int FRAC_BITS  = 16;
	localparam int NUM_STAGES = 8;

	// request kinds on tuser
	typedef enum logic {
		OP_EVAL = 1'b0,
		OP_LOAD = 1'b1
	} pn_op_t;

	typedef logic [TBL_BITS-1:0]  pn_idx_t;
	typedef logic [FRAC_BITS-1:0] pn_frac_t;
	typedef logic [NUM_STAGES:1]  pn_adv_t;

	// table write enables for the first copy and for the two corner copies
	typedef struct packed {
		logic tbl1_we;
		logic tbl23_we;
	} pn_we_t;

	// gradient dot product, 3d gradient rule at z = 0
	function automatic logic signed [18:0] corner_dot(input logic [3:0] h,
		input logic signed [17:0] dx, input logic signed [17:0] dy);
		logic signed [18:0] a;
		logic signed [18:0] b;
		begin
			a = (h < 4'd8) ? 19'(dx) : 19'(dy);
			if (h < 4'd4)
				b = 19'(dy);
			else if (h == 4'd12 || h == 4'd14)
				b = 19'(dx);
			else
				b = '0;
			corner_dot = (h[0] ? -a : a) + (h[1] ? -b : b);
		end
	endfunction

	// shift a signed product right by the fraction width, ties away from zero
	function automatic logic signed [23:0] rnd_prod(input logic signed [39:0] p);
		logic [39:0] mag;
		logic [39:0] r;
		logic signed [23:0] rs;
		begin
			mag = p[39] ? (~p + 40'd1) : p;
			r = (mag + (40'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
			rs = r[23:0];
			rnd_prod = p[39] ? -rs : rs;
		end
	endfunction

endpackage

// ----- sv/pn_fade.sv -----
`timescale 1ns / 1ps
module pn_fade
	import pn_pkg::*;
(
	input  logic                 clk,
	input  pn_adv_t              adv,
	input  pn_frac_t             t,
	output logic [FRAC_BITS:0]   f
);

	localparam logic [33:0] HALF = 34'd1 << (FRAC_BITS - 1);
	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

	logic [31:0]          t2p_s1;
	pn_frac_t             t_s1;
	logic [32:0]          t3p_s2;
	logic [19:0]          q_s2;
	logic [36:0]          fp_s3;
	logic [FRAC_BITS:0]   f_s4;

	logic [16:0]          t2;
	logic [21:0]          q;
	logic [16:0]          t3;
	logic [37:0]          fr;

	// rounded t squared, the quadratic factor, rounded t cubed and the rounded fade product
	always_comb begin
		t2 = 17'((34'(t2p_s1) + HALF) >> FRAC_BITS);
		q  = 22'(655360) + 22'(t2) * 22'd6 - 22'(t_s1) * 22'd15;
		t3 = 17'((34'(t3p_s2) + HALF) >> FRAC_BITS);
		fr = (38'(fp_s3) + 38'(HALF)) >> FRAC_BITS;
	end

	// stage 1: t * t
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			t2p_s1 <= 32'(t) * 32'(t);
			t_s1   <= t;
		end
	end

	// stage 2: t^3 and the quadratic factor
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			t3p_s2 <= 33'(t2) * 33'(t_s1);
			q_s2   <= q[19:0];
		end
	end

	// stage 3: t^3 * (6t^2 - 15t + 10)
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			fp_s3 <= 37'(t3) * 37'(q_s2);
		end
	end

	// stage 4: round and clamp to one
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			f_s4 <= (fr > 38'(ONE)) ? ONE : fr[FRAC_BITS:0];
		end
	end

	assign f = f_s4;

endmodule

// ----- sv/pn_hash.sv -----
`timescale 1ns / 1ps
module pn_hash
	import pn_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  pn_adv_t adv,
	input  pn_we_t  we,
	input  pn_idx_t cx,
	input  pn_idx_t cy,
	input  pn_idx_t load_index,
	input  pn_idx_t load_value,
	output logic    tbl_ready,
	output pn_idx_t h_aa,
	output pn_idx_t h_ab,
	output pn_idx_t h_ba,
	output pn_idx_t h_bb
);

	// three copies of the permutation table: one for the first lookup level, two for the second
	pn_idx_t mem1 [TBL_SIZE];
	pn_idx_t mem2 [TBL_SIZE];
	pn_idx_t mem3 [TBL_SIZE];

	logic [TBL_BITS:0] clr_q;
	logic              clr_busy;
	pn_idx_t           clr_idx;

	pn_idx_t px0_d_s1, px1_d_s1, cy_s1, ldi_s1, ldv_s1;
	pn_idx_t aa_d_s2, ab_d_s2, ba_d_s2, bb_d_s2;

	pn_idx_t cx1, px0, px1, a_aa, a_ab, a_ba, a_bb;

	assign cx1 = cx + pn_idx_t'(1);

	// clearing pass after reset: every copy gets the identity permutation
	assign clr_busy  = !clr_q[TBL_BITS];
	assign clr_idx   = clr_q[TBL_BITS-1:0];
	assign tbl_ready = !clr_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (clr_busy)
			clr_q <= clr_q + (TBL_BITS+1)'(1);
	end

	// first level: entries at cx and cx + 1
	always_ff @(posedge clk) begin
		if (clr_busy)
			mem1[clr_idx] <= clr_idx;
		else if (we.tbl1_we)
			mem1[load_index] <= load_value;
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			px0_d_s1 <= mem1[cx];
			px1_d_s1 <= mem1[cx1];
			cy_s1    <= cy;
			ldi_s1   <= load_index;
			ldv_s1   <= load_value;
		end
	end

	// corner addresses for the second level
	always_comb begin
		px0  = px0_d_s1;
		px1  = px1_d_s1;
		a_aa = px0 + cy_s1;
		a_ab = px0 + cy_s1 + pn_idx_t'(1);
		a_ba = px1 + cy_s1;
		a_bb = px1 + cy_s1 + pn_idx_t'(1);
	end

	// second level: corner hashes
	always_ff @(posedge clk) begin
		if (clr_busy) begin
			mem2[clr_idx] <= clr_idx;
			mem3[clr_idx] <= clr_idx;
		end else if (we.tbl23_we) begin
			mem2[ldi_s1] <= ldv_s1;
			mem3[ldi_s1] <= ldv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			aa_d_s2 <= mem2[a_aa];
			ab_d_s2 <= mem2[a_ab];
			ba_d_s2 <= mem3[a_ba];
			bb_d_s2 <= mem3[a_bb];
		end
	end

	assign h_aa = aa_d_s2;
	assign h_ab = ab_d_s2;
	assign h_ba = ba_d_s2;
	assign h_bb = bb_d_s2;

endmodule

// ----- sv/pn_blend.sv -----
`timescale 1ns / 1ps
module pn_blend
	import pn_pkg::*;
(
	input  logic               clk,
	input  pn_adv_t            adv,
	input  pn_frac_t           fx,
	input  pn_frac_t           fy,
	input  pn_idx_t            h_aa,
	input  pn_idx_t            h_ab,
	input  pn_idx_t            h_ba,
	input  pn_idx_t            h_bb,
	input  logic [FRAC_BITS:0] u,
	input  logic [FRAC_BITS:0] v,
	output logic [16:0]        noise
);

	pn_frac_t fx_s1, fy_s1, fx_s2, fy_s2;
	logic signed [18:0] daa_s3, dab_s3, dba_s3, dbb_s3;
	logic signed [18:0] aa_s4, ab_s4;
	logic signed [19:0] dlo_s4, dhi_s4;
	logic [FRAC_BITS:0] v_s5, v_s6;
	logic signed [18:0] aa_s5, ab_s5;
	logic signed [39:0] plo_s5, phi_s5;
	logic signed [21:0] lo_s6, hi_s6;
	logic signed [21:0] lo_s7;
	logic signed [39:0] pr_s7;
	logic [16:0]        noise_s8;

	logic signed [17:0] dx0, dx1, dy0, dy1;
	logic signed [23:0] lo, hi, r, n;
	logic [23:0]        res;

	// corner offsets: f and f - 1
	always_comb begin
		dx0 = {2'b00, fx_s2};
		dx1 = {2'b11, fx_s2};
		dy0 = {2'b00, fy_s2};
		dy1 = {2'b11, fy_s2};
	end

	// fraction delay to line up with the hashes
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			fx_s1 <= fx;
			fy_s1 <= fy;
		end
		if (adv[2]) begin
			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;
		end
	end

	// stage 3: gradient dot products
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			daa_s3 <= corner_dot(h_aa[3:0], dx0, dy0);
			dba_s3 <= corner_dot(h_ba[3:0], dx1, dy0);
			dab_s3 <= corner_dot(h_ab[3:0], dx0, dy1);
			dbb_s3 <= corner_dot(h_bb[3:0], dx1, dy1);
		end
	end

	// stage 4: differences along x
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			aa_s4  <= daa_s3;
			ab_s4  <= dab_s3;
			dlo_s4 <= 20'(dba_s3) - 20'(daa_s3);
			dhi_s4 <= 20'(dbb_s3) - 20'(dab_s3);
		end
	end

	// stage 5: products with the x fade; both fades belong to the stage 4 request
	always_ff @(posedge clk) begin
		if (adv[5]) begin
			plo_s5 <= 40'($signed({1'b0, u})) * 40'(dlo_s4);
			phi_s5 <= 40'($signed({1'b0, u})) * 40'(dhi_s4);
			aa_s5  <= aa_s4;
			ab_s5  <= ab_s4;
			v_s5   <= v;
		end
	end

	assign lo = 24'(aa_s5) + rnd_prod(plo_s5);
	assign hi = 24'(ab_s5) + rnd_prod(phi_s5);

	// stage 6: blended rows
	always_ff @(posedge clk) begin
		if (adv[6]) begin
			lo_s6 <= lo[21:0];
			hi_s6 <= hi[21:0];
			v_s6  <= v_s5;
		end
	end

	// stage 7: product with the y fade
	always_ff @(posedge clk) begin
		if (adv[7]) begin
			pr_s7 <= 40'($signed({1'b0, v_s6})) * (40'(hi_s6) - 40'(lo_s6));
			lo_s7 <= lo_s6;
		end
	end

	// map to zero..one, round by one bit and saturate
	always_comb begin
		r   = 24'(lo_s7) + rnd_prod(pr_s7);
		n   = r + 24'sd65536;
		res = n[23] ? 24'd0 : ((24'(n) + 24'd1) >> 1);
		if (res > 24'd65536)
			res = 24'd65536;
	end

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			noise_s8 <= res[16:0];
		end
	end

	assign noise = noise_s8;

endmodule

// ----- sv/perlin_noise_2d.sv -----
`timescale 1ns / 1ps
// an accepted evaluate request moves through the stage registers to its result on m_tdata
// throughput: one request per cycle, loads included, unless the clearing pass or a stall from m_tready holds the input
// table copies are read at stages 1 and 2; loads write each copy at that stage
// reset: pipeline empty; a clearing pass over all 256 entries then loads the identity
// permutation into every table copy, with s_tready low until it ends
module perlin_noise_2d
	import pn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // x_coord[31:0], y_coord[31:0], load_index[7:0], load_value[7:0]
	input  logic        s_tuser,  // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // noise_value[16:0], zero pad[23:17]
);

	logic [NUM_STAGES:1] vld_s;
	logic                op_s1, op_s2;
	logic [NUM_STAGES+1:1] rdy;
	pn_adv_t             adv;
	pn_we_t              we;
	logic                tbl_ready;

	logic [31:0] x_coord, y_coord;
	pn_idx_t     load_index, load_value, cx, cy;
	pn_idx_t     h_aa, h_ab, h_ba, h_bb;
	logic [FRAC_BITS:0] u, v;
	logic [16:0] noise;

	// request fields
	assign x_coord    = s_tdata[31:0];
	assign y_coord    = s_tdata[63:32];
	assign load_index = s_tdata[71:64];
	assign load_value = s_tdata[79:72];
	assign cx         = x_coord[FRAC_BITS +: TBL_BITS];
	assign cy         = y_coord[FRAC_BITS +: TBL_BITS];

	// a stage takes new data when it is empty or its successor moves
	always_comb begin
		rdy[NUM_STAGES+1] = m_tready;
		for (int k = NUM_STAGES; k >= 1; k--)
			rdy[k] = !vld_s[k] || rdy[k+1];
		adv = rdy[NUM_STAGES:1];
	end

	assign s_tready    = rdy[1] && tbl_ready;
	assign we.tbl1_we  = s_tvalid && s_tready && (pn_op_t'(s_tuser) == OP_LOAD);
	assign we.tbl23_we = vld_s[1] && (pn_op_t'(op_s1) == OP_LOAD) && rdy[2];

	// valid chain; loads drop out after the last table copy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			op_s1 <= 1'b0;
			op_s2 <= 1'b0;
		end else begin
			if (rdy[1]) begin
				vld_s[1] <= s_tvalid && s_tready;
				op_s1    <= s_tuser;
			end
			if (rdy[2]) begin
				vld_s[2] <= vld_s[1];
				op_s2    <= op_s1;
			end
			if (rdy[3])
				vld_s[3] <= vld_s[2] && (pn_op_t'(op_s2) == OP_EVAL);
			for (int k = 4; k <= NUM_STAGES; k++)
				if (rdy[k])
					vld_s[k] <= vld_s[k-1];
		end
	end

	pn_hash u_hash (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.we         (we),
		.cx         (cx),
		.cy         (cy),
		.load_index (load_index),
		.load_value (load_value),
		.tbl_ready  (tbl_ready),
		.h_aa       (h_aa),
		.h_ab       (h_ab),
		.h_ba       (h_ba),
		.h_bb       (h_bb)
	);

	pn_fade u_fade_x (
		.clk (clk),
		.adv (adv),
		.t   (x_coord[FRAC_BITS-1:0]),
		.f   (u)
	);

	pn_fade u_fade_y (
		.clk (clk),
		.adv (adv),
		.t   (y_coord[FRAC_BITS-1:0]),
		.f   (v)
	);

	pn_blend u_blend (
		.clk   (clk),
		.adv   (adv),
		.fx    (x_coord[FRAC_BITS-1:0]),
		.fy    (y_coord[FRAC_BITS-1:0]),
		.h_aa  (h_aa),
		.h_ab  (h_ab),
		.h_ba  (h_ba),
		.h_bb  (h_bb),
		.u     (u),
		.v     (v),
		.noise (noise)
	);

	assign m_tvalid = vld_s[NUM_STAGES];
	assign m_tdata  = {7'd0, noise};

	// result stays within zero..one
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[16:0] <= 17'd65536))
		else $error("noise out of range");

	// fade outputs clamp to one
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[5] |-> (u <= 17'd65536 && v <= 17'd65536))
		else $error("fade out of range");

	// a held first stage blocks new requests
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[1] && !rdy[2]) |-> !s_tready)
		else $error("request taken while stage 1 is held");

	// loads never reach the blend stages
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[2] && (pn_op_t'(op_s2) == OP_LOAD) && rdy[3]) |=> !vld_s[3])
		else $error("load request leaked into blend");

endmodule

// ----- bench/perlin_noise_2d_tb.sv -----
`timescale 1ns / 1ps
module perlin_noise_2d_tb;
	import pn_pkg::*;

	typedef struct {
		pn_op_t          op;
		logic [31:0]     x_coord;
		logic [31:0]     y_coord;
		logic [7:0]      load_index;
		logic [7:0]      load_value;
	} pn_req_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	pn_req_t     pending_reqs[$];
	logic [16:0] expected_noise[$];
	logic [7:0]  perm_copy[TBL_SIZE];
	int          mismatch_count;
	int          eval_count;
	int          load_count;
	int          noise_seen;
	int          src_idle_pct;
	int          sink_idle_pct;

	perlin_noise_2d dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// rounding shift by the fraction width, ties away from zero
	function automatic longint round_q(input longint v);
		longint half;
		half = longint'(1) << (FRAC_BITS - 1);
		if (v >= 0)
			return (v + half) >>> FRAC_BITS;
		return -((-v + half) >>> FRAC_BITS);
	endfunction

	function automatic longint fade_curve(input longint t);
		longint t2, t3, q, f;
		t2 = round_q(t * t);
		t3 = round_q(t2 * t);
		q = 6 * t2 - 15 * t + 10 * (longint'(1) << FRAC_BITS);
		f = round_q(t3 * q);
		if (f > (longint'(1) << FRAC_BITS))
			f = longint'(1) << FRAC_BITS;
		if (f < 0)
			f = 0;
		return f;
	endfunction

	function automatic longint lerp_q(input longint t, input longint a, input longint b);
		return a + round_q(t * (b - a));
	endfunction

	function automatic longint grad_dot(input logic [7:0] hash, input longint dx,
		input longint dy);
		logic [3:0] h;
		longint a, b;
		h = hash[3:0];
		a = (h < 8) ? dx : dy;
		if (h < 4)
			b = dy;
		else if (h == 12 || h == 14)
			b = dx;
		else
			b = 0;
		return (h[0] ? -a : a) + (h[1] ? -b : b);
	endfunction

	// expected noise for one point against the current table copy
	function automatic logic [16:0] noise_at(input logic [31:0] xc, input logic [31:0] yc);
		logic [7:0] cx, cy, px0, px1, aa, ab, ba, bb;
		longint fx, fy, u, v, lo, hi, n, one;
		one = longint'(1) << FRAC_BITS;
		cx = xc[FRAC_BITS +: 8];
		cy = yc[FRAC_BITS +: 8];
		fx = longint'(xc[FRAC_BITS-1:0]);
		fy = longint'(yc[FRAC_BITS-1:0]);
		u = fade_curve(fx);
		v = fade_curve(fy);
		px0 = perm_copy[cx];
		px1 = perm_copy[8'(cx + 8'd1)];
		aa = perm_copy[8'(px0 + cy)];
		ab = perm_copy[8'(px0 + cy + 8'd1)];
		ba = perm_copy[8'(px1 + cy)];
		bb = perm_copy[8'(px1 + cy + 8'd1)];
		lo = lerp_q(u, grad_dot(aa, fx, fy), grad_dot(ba, fx - one, fy));
		hi = lerp_q(u, grad_dot(ab, fx, fy - one), grad_dot(bb, fx - one, fy - one));
		n = lerp_q(v, lo, hi) + one;
		if (n < 0)
			n = 0;
		// Q.16 to Q1.16 is a shift by one, rounded
		n = (n + 1) >>> 1;
		if (n > 65536)
			n = 65536;
		return 17'(n);
	endfunction

	task automatic report_mismatch(input string what, input logic [16:0] got,
		input logic [16:0] want);
		$display("error at %0t: %s got %0d expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	function automatic pn_req_t make_eval(input logic [31:0] xc, input logic [31:0] yc);
		pn_req_t r;
		r.op = OP_EVAL;
		r.x_coord = xc;
		r.y_coord = yc;
		r.load_index = 8'($urandom);
		r.load_value = 8'($urandom);
		return r;
	endfunction

	function automatic pn_req_t make_load(input logic [7:0] idx, input logic [7:0] val);
		pn_req_t r;
		r.op = OP_LOAD;
		r.x_coord = $urandom;
		r.y_coord = $urandom;
		r.load_index = idx;
		r.load_value = val;
		return r;
	endfunction

	// random coordinate: full range, small cells around zero, or fraction edges and the half point
	function automatic logic [31:0] rand_coord();
		logic [31:0] c;
		c = $urandom;
		case ($urandom_range(0, 5))
			0: c[31:FRAC_BITS] = 16'($signed($urandom_range(0, 15)) - 8);
			1: c[FRAC_BITS-1:0] = 16'($urandom_range(0, 3));
			2: c[FRAC_BITS-1:0] = 16'(32'hFFFF - $urandom_range(0, 3));
			3: c[FRAC_BITS-1:0] = 16'h8000;
			default: ;
		endcase
		return c;
	endfunction

	// driver: requests go out in queue order, predictions made on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (pn_op_t'(s_tuser) == OP_LOAD) begin
					perm_copy[s_tdata[71:64]] = s_tdata[79:72];
					load_count++;
				end else begin
					expected_noise.push_back(noise_at(s_tdata[31:0], s_tdata[63:32]));
					eval_count++;
				end
			end
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					pn_req_t r;
					r = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= r.op;
					s_tdata  <= {r.load_value, r.load_index, r.y_coord, r.x_coord};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				noise_seen++;
				if (expected_noise.size() == 0) begin
					report_mismatch("unexpected noise", m_tdata[16:0], 17'd0);
				end else begin
					logic [16:0] want;
					want = expected_noise.pop_front();
					if (m_tdata[16:0] !== want)
						report_mismatch("noise_value", m_tdata[16:0], want);
					if (m_tdata[23:17] !== 7'd0)
						report_mismatch("pad bits", 17'(m_tdata[23:17]), 17'd0);
				end
			end
			m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	task automatic drain_queue();
		while (pending_reqs.size() > 0 || s_tvalid)
			@(posedge clk);
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		mismatch_count = 0;
		eval_count = 0;
		load_count = 0;
		noise_seen = 0;
		src_idle_pct = 9;
		sink_idle_pct = 78;
		for (i = 0; i < TBL_SIZE; i++)
			perm_copy[i] = 8'(i);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, identity table, then loads
		pending_reqs.push_back(make_eval(32'h0, 32'h0));
		pending_reqs.push_back(make_eval(32'h7FFF_FFFF, 32'h7FFF_FFFF));
		pending_reqs.push_back(make_eval(32'h8000_0000, 32'h8000_0000));
		pending_reqs.push_back(make_eval(32'hFFFF_FFFF, 32'h0000_0001));
		pending_reqs.push_back(make_eval(32'h00FF_8000, 32'hFFFF_8000));
		pending_reqs.push_back(make_eval(32'h0000_8000, 32'h0000_8000));
		pending_reqs.push_back(make_eval(32'h0000_FFFF, 32'hFFFF_0000));
		pending_reqs.push_back(make_eval(32'h5555_AAAA, 32'hAAAA_5555));
		pending_reqs.push_back(make_load(8'd0, 8'd255));
		pending_reqs.push_back(make_load(8'd255, 8'd0));
		pending_reqs.push_back(make_eval(32'h00FF_4000, 32'h0000_C000));
		pending_reqs.push_back(make_load(8'd1, 8'd1));
		pending_reqs.push_back(make_load(8'hAA, 8'h55));
		// load right before an evaluate that reads the entry
		pending_reqs.push_back(make_load(8'd0, 8'd12));
		pending_reqs.push_back(make_eval(32'h0000_1234, 32'h0000_4321));
		pending_reqs.push_back(make_eval(32'hFFFF_1234, 32'hFFFF_4321));
		for (i = 0; i < 8; i++)
			pending_reqs.push_back(make_eval({16'($urandom_range(0, 255)), 16'($urandom)},
				$urandom));

		// random: evaluates with scattered table loads, three idle phases
		for (int phase = 0; phase < 3; phase++) begin
			for (i = 0; i < 410; i++) begin
				if ($urandom_range(0, 9) < 2)
					pending_reqs.push_back(make_load(8'($urandom), 8'($urandom)));
				else
					pending_reqs.push_back(make_eval(rand_coord(), rand_coord()));
			end
			drain_queue();
			if (phase == 0) begin
				src_idle_pct = 78;
				sink_idle_pct = 9;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
		end

		// wait for the last results, then for the pipeline to empty
		while (expected_noise.size() > 0)
			@(posedge clk);
		repeat (NUM_STAGES + 8) @(posedge clk);
		$display("covered %0d evaluate and %0d table load requests, %0d results checked",
			eval_count, load_count, noise_seen);
		if (mismatch_count == 0)
			$display("perlin_noise_2d: match");
		else
			$display("perlin_noise_2d: mismatch");
		$finish;
	end

	// run limit
	initial begin
		#4000000;
		$display("timeout");
		$display("perlin_noise_2d: mismatch");
		$finish;
	end

endmodule
